// File: sv/dpb_pkg.sv
`default_nettype none

package dpb_pkg;

   // field widths fixed by the pixel and point formats
   localparam int DEPTH_W    = 16;
   localparam int COORD_W    = 12;
   localparam int COLOUR_W   = 8;
   localparam int RECIP_W    = 24;
   localparam int CENTRE_W   = 16;
   localparam int POINT_W    = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // pipeline depth from input register to output register
   localparam int NSTAGE = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_METRES_PER_COUNT = 3'd0,
      CSR_INV_FOCAL_X      = 3'd1,
      CSR_INV_FOCAL_Y      = 3'd2,
      CSR_CENTRE_X         = 3'd3,
      CSR_CENTRE_Y         = 3'd4
   } csr_index_type;

   localparam logic [RECIP_W-1:0]  RST_METRES_PER_COUNT = 24'd16777;
   localparam logic [RECIP_W-1:0]  RST_INV_FOCAL_X      = 24'd32389;
   localparam logic [RECIP_W-1:0]  RST_INV_FOCAL_Y      = 24'd32389;
   localparam logic [CENTRE_W-1:0] RST_CENTRE_X         = 16'd5208;
   localparam logic [CENTRE_W-1:0] RST_CENTRE_Y         = 16'd4056;

   typedef struct packed {
      logic [DEPTH_W-1:0]  depth_value;
      logic [COORD_W-1:0]  pixel_row;
      logic [COORD_W-1:0]  pixel_col;
      logic [COLOUR_W-1:0] blue_in;
      logic [COLOUR_W-1:0] green_in;
      logic [COLOUR_W-1:0] red_in;
   } req_type;

   typedef struct packed {
      logic signed [POINT_W-1:0] point_x;
      logic signed [POINT_W-1:0] point_y;
      logic [POINT_W-1:0]        point_z;
      logic [COLOUR_W-1:0]       blue_out;
      logic [COLOUR_W-1:0]       green_out;
      logic [COLOUR_W-1:0]       red_out;
   } rsp_type;

   // per-stage load enables shared by every datapath slice
   typedef struct packed {
      logic [NSTAGE-1:0] adv;
   } pipe_ctl_type;

endpackage

`default_nettype wire

// File: sv/dpb_zscale.sv
`default_nettype none

module dpb_zscale (
   input  wire logic                          clock,
   input  wire dpb_pkg::pipe_ctl_type         ctl,
   input  wire logic [dpb_pkg::DEPTH_W-1:0]   depth,
   input  wire logic [dpb_pkg::RECIP_W-1:0]   metres_per_count,
   output logic      [dpb_pkg::POINT_W-1:0]   z
);

   localparam int PROD_W = dpb_pkg::DEPTH_W + dpb_pkg::RECIP_W;

   logic [PROD_W-1:0]           prod_ff;
   logic [dpb_pkg::POINT_W-1:0] z_ff;
   logic [PROD_W:0]             round_in;
   logic [PROD_W-8:0]           shifted_in;
   logic [dpb_pkg::POINT_W-1:0] z_in;

   // stage 0: depth times metres per count, Q16.24
   always_ff @(posedge clock) begin
      if (ctl.adv[0]) begin
         prod_ff <= depth * metres_per_count;
      end
   end

   // stage 1: round half up to Q8.16 and clamp
   always_comb begin
      round_in   = {1'b0, prod_ff} + (PROD_W + 1)'(128);
      shifted_in = round_in[PROD_W:8];
      if (|shifted_in[PROD_W-8:dpb_pkg::POINT_W]) begin
         z_in = {dpb_pkg::POINT_W{1'b1}};
      end else begin
         z_in = shifted_in[dpb_pkg::POINT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[1]) begin
         z_ff <= z_in;
      end
   end

   assign z = z_ff;

endmodule

`default_nettype wire

// File: sv/dpb_lateral.sv
`default_nettype none

module dpb_lateral (
   input  wire logic                           clock,
   input  wire dpb_pkg::pipe_ctl_type          ctl,
   input  wire logic [dpb_pkg::COORD_W-1:0]    coord,
   input  wire logic [dpb_pkg::CENTRE_W-1:0]   centre,
   input  wire logic [dpb_pkg::RECIP_W-1:0]    inv_focal,
   input  wire logic [dpb_pkg::POINT_W-1:0]    z,
   output logic signed [dpb_pkg::POINT_W-1:0]  result
);

   localparam int PIX_W  = dpb_pkg::COORD_W + 4;
   localparam int MAG_W  = (PIX_W > dpb_pkg::CENTRE_W) ? PIX_W : dpb_pkg::CENTRE_W;
   localparam int ZI_W   = dpb_pkg::POINT_W + dpb_pkg::RECIP_W;
   localparam int HALF_W = ZI_W / 2;
   localparam int PART_W = MAG_W + HALF_W;
   localparam int FULL_W = 64;
   localparam int Q_W    = FULL_W - 28;

   localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(24'h800000);
   localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(24'h7FFFFF);

   logic [PIX_W-1:0]  pix_in;
   logic              neg_in;
   logic [MAG_W-1:0]  mag_in;

   logic [MAG_W-1:0]  mag0_ff, mag1_ff, mag2_ff;
   logic              neg0_ff, neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [ZI_W-1:0]   zi_ff;
   logic [PART_W-1:0] lo_ff, hi_ff;
   logic [FULL_W:0]   sum_in;
   logic [Q_W-1:0]    q_ff;
   logic [dpb_pkg::POINT_W-1:0] sat_in;
   logic signed [dpb_pkg::POINT_W-1:0] res_ff;

   // stage 0: offset from the principal point, Q12.4, as sign and magnitude
   always_comb begin
      pix_in = {coord, 4'b0000};
      neg_in = MAG_W'(pix_in) < MAG_W'(centre);
      mag_in = neg_in ? (MAG_W'(centre) - MAG_W'(pix_in))
                      : (MAG_W'(pix_in) - MAG_W'(centre));
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[0]) begin
         mag0_ff <= mag_in;
         neg0_ff <= neg_in;
      end
      // stage 1: wait for z
      if (ctl.adv[1]) begin
         mag1_ff <= mag0_ff;
         neg1_ff <= neg0_ff;
      end
      // stage 2: z times reciprocal focal length
      if (ctl.adv[2]) begin
         zi_ff   <= z * inv_focal;
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
      end
      // stage 3: magnitude times each half of the scaled depth
      if (ctl.adv[3]) begin
         lo_ff   <= mag2_ff * zi_ff[HALF_W-1:0];
         hi_ff   <= mag2_ff * zi_ff[ZI_W-1:HALF_W];
         neg3_ff <= neg2_ff;
      end
      // stage 4: join partials, round half away from zero
      if (ctl.adv[4]) begin
         q_ff    <= sum_in[FULL_W-1:28];
         neg4_ff <= neg3_ff;
      end
      // stage 5: clamp and apply the sign
      if (ctl.adv[5]) begin
         res_ff <= neg4_ff ? -$signed(sat_in) : $signed(sat_in);
      end
   end

   always_comb begin
      sum_in = (FULL_W + 1)'({hi_ff, {HALF_W{1'b0}}}) + (FULL_W + 1)'(lo_ff)
             + (FULL_W + 1)'(64'd1 << 27);
   end

   always_comb begin
      if (neg4_ff) begin
         sat_in = (q_ff > NEG_LIMIT) ? NEG_LIMIT[dpb_pkg::POINT_W-1:0]
                                     : q_ff[dpb_pkg::POINT_W-1:0];
      end else begin
         sat_in = (q_ff > POS_LIMIT) ? POS_LIMIT[dpb_pkg::POINT_W-1:0]
                                     : q_ff[dpb_pkg::POINT_W-1:0];
      end
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// File: sv/depth_to_point_backprojection.sv
`default_nettype none

// Pinhole back-projection of a depth pixel stream into coloured 3D points.
// Each req_ item carries one depth pixel with its row, column and BGR colour.
// Items on an odd row or odd column, and items with zero depth, give no
// result; every other item gives one rsp_ item with z = depth * metres per
// count and x, y = (pixel - centre) * z * reciprocal focal length, all Q8.16
// metres, rounded and saturated, with the colour carried along unchanged.
// The block takes one item every clock cycle unless every stage is full and
// stalled; its six register stages are set by the depth multiply, its
// rounding, the reciprocal multiply, the split 16 x 48 lateral multiply,
// the rounding add and the final clamp. Each stage holds its item
// only while the stage after it is full and stalled, so bubbles close up and
// rsp_ready low never drops or repeats an item. Registers are written through
// csr_ with csr_we; write them only while no item is in flight.
module depth_to_point_backprojection #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire dpb_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output dpb_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [dpb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dpb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int NST = dpb_pkg::NSTAGE;
   // only the low COORD_BITS bits of a coordinate count
   localparam int CW  = (COORD_BITS < dpb_pkg::COORD_W) ? COORD_BITS : dpb_pkg::COORD_W;
   localparam logic [dpb_pkg::COORD_W-1:0] COORD_MASK =
      {dpb_pkg::COORD_W{1'b1}} >> (dpb_pkg::COORD_W - CW);

   typedef struct packed {
      logic [dpb_pkg::COLOUR_W-1:0] blue;
      logic [dpb_pkg::COLOUR_W-1:0] green;
      logic [dpb_pkg::COLOUR_W-1:0] red;
   } colour_type;

   // configuration registers
   logic [dpb_pkg::RECIP_W-1:0]  mpc_ff;
   logic [dpb_pkg::RECIP_W-1:0]  ifx_ff;
   logic [dpb_pkg::RECIP_W-1:0]  ify_ff;
   logic [dpb_pkg::CENTRE_W-1:0] cx_ff;
   logic [dpb_pkg::CENTRE_W-1:0] cy_ff;

   logic [NST-1:0]               v_ff;
   logic [NST-1:0]               v_in;
   logic [NST-1:0]               ready;
   dpb_pkg::pipe_ctl_type        ctl;

   logic [dpb_pkg::COORD_W-1:0]  row_m;
   logic [dpb_pkg::COORD_W-1:0]  col_m;
   logic                         keep;

   colour_type                   colour_ff [NST];
   logic [dpb_pkg::POINT_W-1:0]  z_ff [2:NST-1];
   logic [dpb_pkg::POINT_W-1:0]  z_s1;
   logic signed [dpb_pkg::POINT_W-1:0] x_res;
   logic signed [dpb_pkg::POINT_W-1:0] y_res;

   // register writes; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mpc_ff <= dpb_pkg::RST_METRES_PER_COUNT;
         ifx_ff <= dpb_pkg::RST_INV_FOCAL_X;
         ify_ff <= dpb_pkg::RST_INV_FOCAL_Y;
         cx_ff  <= dpb_pkg::RST_CENTRE_X;
         cy_ff  <= dpb_pkg::RST_CENTRE_Y;
      end else if (csr_we) begin
         unique case (csr_index)
            dpb_pkg::CSR_METRES_PER_COUNT: mpc_ff <= csr_wdata;
            dpb_pkg::CSR_INV_FOCAL_X:      ifx_ff <= csr_wdata;
            dpb_pkg::CSR_INV_FOCAL_Y:      ify_ff <= csr_wdata;
            dpb_pkg::CSR_CENTRE_X:         cx_ff  <= csr_wdata[dpb_pkg::CENTRE_W-1:0];
            dpb_pkg::CSR_CENTRE_Y:         cy_ff  <= csr_wdata[dpb_pkg::CENTRE_W-1:0];
            default: ;
         endcase
      end
   end

   // a stage loads when it is empty or its item moves on this cycle
   always_comb begin
      ready[NST-1] = !v_ff[NST-1] || rsp_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         ready[k] = !v_ff[k] || ready[k+1];
      end
   end

   assign ctl.adv   = ready;
   assign req_ready = ready[0];

   // drop odd rows, odd columns and missing depth at the door
   always_comb begin
      row_m = req_data.pixel_row & COORD_MASK;
      col_m = req_data.pixel_col & COORD_MASK;
      keep  = (req_data.depth_value != '0) && !row_m[0] && !col_m[0];
   end

   always_comb begin
      v_in[0] = ready[0] ? (req_valid && keep) : v_ff[0];
      for (int k = 1; k < NST; k++) begin
         v_in[k] = ready[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // colour rides along with its item
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         colour_ff[0] <= '{blue:  req_data.blue_in,
                           green: req_data.green_in,
                           red:   req_data.red_in};
      end
      for (int k = 1; k < NST; k++) begin
         if (ready[k]) begin
            colour_ff[k] <= colour_ff[k-1];
         end
      end
   end

   // z leaves the scaler after stage 1; hold it to the output
   always_ff @(posedge clock) begin
      if (ready[2]) begin
         z_ff[2] <= z_s1;
      end
      for (int k = 3; k < NST; k++) begin
         if (ready[k]) begin
            z_ff[k] <= z_ff[k-1];
         end
      end
   end

   dpb_zscale u_zscale (
      .clock            (clock),
      .ctl              (ctl),
      .depth            (req_data.depth_value),
      .metres_per_count (mpc_ff),
      .z                (z_s1)
   );

   dpb_lateral u_lateral_x (
      .clock     (clock),
      .ctl       (ctl),
      .coord     (col_m),
      .centre    (cx_ff),
      .inv_focal (ifx_ff),
      .z         (z_s1),
      .result    (x_res)
   );

   dpb_lateral u_lateral_y (
      .clock     (clock),
      .ctl       (ctl),
      .coord     (row_m),
      .centre    (cy_ff),
      .inv_focal (ify_ff),
      .z         (z_s1),
      .result    (y_res)
   );

   assign rsp_valid          = v_ff[NST-1];
   assign rsp_data.point_x   = x_res;
   assign rsp_data.point_y   = y_res;
   assign rsp_data.point_z   = z_ff[NST-1];
   assign rsp_data.blue_out  = colour_ff[NST-1].blue;
   assign rsp_data.green_out = colour_ff[NST-1].green;
   assign rsp_data.red_out   = colour_ff[NST-1].red;

   // a pixel with no depth never occupies the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.depth_value == '0)) |=> !v_ff[0])
      else $error("zero-depth pixel entered the pipeline");

   // an empty stage anywhere lets the input side take an item
   assert property (@(posedge clock) disable iff (reset)
      (v_ff != {NST{1'b1}}) |-> req_ready)
      else $error("input stalled while the pipeline has room");

   // zero range forces zero lateral offsets
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.point_z == '0)) |->
         (rsp_data.point_x == '0) && (rsp_data.point_y == '0))
      else $error("nonzero lateral coordinate with zero z");

   // a stalled output item stays in the last stage
   assert property (@(posedge clock) disable iff (reset)
      (v_ff[NST-1] && !rsp_ready) |=> v_ff[NST-1])
      else $error("stalled result lost");

endmodule

`default_nettype wire
